[rtl/core/pfcb_pkg.sv]
// ----------------------------------------------------------------------------
// pfcb_pkg
// Shared types and constants of the page framebuffer column blitter: command
// codes, input word layout and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pfcb_pkg;

  // Command codes carried in the low bits of the input word.
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Input word layout, lowest field first.
  localparam int CMD_LSB  = 0;
  localparam int X_LSB    = 2;
  localparam int Y_LSB    = 9;
  localparam int BITS_LSB = 15;
  localparam int IN_W     = 24;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted input word
    logic clr_wr;      // write zero at the clear counter, advance it
    logic draw_rd0;    // read the upper page byte
    logic draw_wr0;    // write the merged upper page byte
    logic draw_rd1;    // read the lower (spill) page byte
    logic draw_wr1;    // write the merged lower page byte
    logic rd_issue;    // read the byte at the read pointer
    logic rd_load;     // move read data to the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // clear counter is at the final byte
    logic spill;       // the shifted bitmap reaches the next page
    logic out_free;    // output register can take a word this cycle
  } dp_sts_t;

endpackage

[rtl/core/pfcb_ctrl.sv]
// ----------------------------------------------------------------------------
// pfcb_ctrl
// Controller state machine: sequences draw read-modify-write, byte reads and
// the clearing sweep over the frame store.
// ----------------------------------------------------------------------------
module pfcb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  output pfcb_pkg::ctrl_cmd_t cmd,
  input  pfcb_pkg::dp_sts_t   sts
);
  import pfcb_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLEAR    = 3'd1;
  localparam logic [2:0] S_DRAW_RD  = 3'd2;
  localparam logic [2:0] S_DRAW_WR0 = 3'd3;
  localparam logic [2:0] S_DRAW_WR1 = 3'd4;
  localparam logic [2:0] S_READ_RD  = 3'd5;
  localparam logic [2:0] S_READ_OUT = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_cmd)
            CMD_DRAW:  state_nxt = S_DRAW_RD;
            CMD_CLEAR: state_nxt = S_CLEAR;
            CMD_READ:  state_nxt = S_READ_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DRAW_RD: begin
        cmd.draw_rd0 = 1'b1;
        state_nxt    = S_DRAW_WR0;
      end
      S_DRAW_WR0: begin
        cmd.draw_wr0 = 1'b1;
        if (sts.spill) begin
          cmd.draw_rd1 = 1'b1;
          state_nxt    = S_DRAW_WR1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DRAW_WR1: begin
        cmd.draw_wr1 = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_READ_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_READ_OUT;
      end
      S_READ_OUT: begin
        if (sts.out_free) begin
          cmd.rd_load = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts with the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // Only one source drives the memory write port at a time.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.draw_wr0, cmd.draw_wr1}))
    else $error("pfcb_ctrl: more than one write source");

  // The spill write always directly follows the upper page write.
  a_spill_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_wr1 |-> $past(cmd.draw_wr0) && $past(sts.spill))
    else $error("pfcb_ctrl: spill write out of order");

  // No new item is taken while an issued memory read is still pending.
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> !cmd.load_item && !in_ready)
    else $error("pfcb_ctrl: item taken while a read is pending");
`endif

endmodule

[rtl/core/pfcb_datapath.sv]
// ----------------------------------------------------------------------------
// pfcb_datapath
// Frame store memory, item register, index and merge logic, read pointer,
// clear counter, blend register and the output word register.
// ----------------------------------------------------------------------------
module pfcb_datapath #(
  parameter int SCREEN_COLUMNS = 84,
  parameter int SCREEN_ROWS    = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [pfcb_pkg::IN_W-1:0] in_word,
  input  logic                    cfg_we,
  input  logic                    cfg_blend,
  input  pfcb_pkg::ctrl_cmd_t     cmd,
  output pfcb_pkg::dp_sts_t       sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last
);
  import pfcb_pkg::*;

  localparam int STORE_SIZE = SCREEN_COLUMNS * SCREEN_ROWS / 8;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int IDX_W      = $clog2(8 * SCREEN_COLUMNS + 128);
  localparam logic [IDX_W-1:0]  STORE_IDX = IDX_W'(STORE_SIZE);
  localparam logic [IDX_W-1:0]  COLS_IDX  = IDX_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

  logic [7:0]        mem [STORE_SIZE];
  logic [7:0]        rdata_r;
  logic [6:0]        x_r;
  logic [5:0]        y_r;
  logic [7:0]        bits_r;
  logic              blend_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  logic [15:0]       shifted;
  logic [IDX_W-1:0]  idx0;
  logic [IDX_W-1:0]  idx1;
  logic              idx0_ok;
  logic              idx1_ok;
  logic [7:0]        new_byte;
  logic [7:0]        merged;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  // Shifted bitmap and the linear indexes of both pages.
  always_comb begin
    shifted = {8'h00, bits_r} << y_r[2:0];
    idx0    = IDX_W'(y_r[5:3]) * COLS_IDX + IDX_W'(x_r);
    idx1    = idx0 + COLS_IDX;
    idx0_ok = idx0 < STORE_IDX;
    idx1_ok = idx1 < STORE_IDX;
  end

  // Merge of the new page byte with the stored one.
  always_comb begin
    new_byte = cmd.draw_wr1 ? shifted[15:8] : shifted[7:0];
    merged   = blend_r ? (rdata_r | new_byte) : new_byte;
  end

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt_r;
    wdata = 8'h00;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.draw_wr0) begin
      we    = idx0_ok;
      waddr = idx0[ADDR_W-1:0];
      wdata = merged;
    end else if (cmd.draw_wr1) begin
      we    = idx1_ok;
      waddr = idx1[ADDR_W-1:0];
      wdata = merged;
    end
    re    = cmd.draw_rd0 || cmd.draw_rd1 || cmd.rd_issue;
    raddr = ptr_r;
    if (cmd.draw_rd0) begin
      raddr = idx0[ADDR_W-1:0];
    end else if (cmd.draw_rd1) begin
      raddr = idx1[ADDR_W-1:0];
    end
  end

  // Frame store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Item register.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x_r    <= in_word[X_LSB +: 7];
      y_r    <= in_word[Y_LSB +: 6];
      bits_r <= in_word[BITS_LSB +: 8];
    end
  end

  // Blend register, read pointer and clear counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_r   <= 1'b1;
      ptr_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        blend_r <= cfg_blend;
      end
      if (cmd.rd_load) begin
        ptr_r <= (ptr_r == LAST_ADDR) ? '0 : ptr_r + 1'b1;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= (clr_cnt_r == LAST_ADDR) ? '0 : clr_cnt_r + 1'b1;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rd_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      out_byte_r <= rdata_r;
      out_last_r <= (ptr_r == LAST_ADDR);
    end
  end

  always_comb begin
    sts.clr_last = (clr_cnt_r == LAST_ADDR);
    sts.spill    = (y_r[2:0] != 3'd0) && (shifted[15:8] != 8'h00);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  // The read pointer stays inside the store.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= LAST_ADDR)
    else $error("pfcb_datapath: read pointer out of range");

  // A loaded read advances the pointer by one or wraps it to zero.
  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_load |=> (ptr_r == $past(ptr_r) + 1'b1) || (ptr_r == '0))
    else $error("pfcb_datapath: read pointer step wrong");

  // The last flag marks exactly the byte read at the final address.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_load |=> out_last_r == (ptr_r == '0))
    else $error("pfcb_datapath: last flag disagrees with pointer");
`endif

endmodule

[rtl/core/page_framebuffer_column_blitter.sv]
// ----------------------------------------------------------------------------
// page_framebuffer_column_blitter
// Monochrome framebuffer in 8-pixel vertical pages with column draw, clear
// and sequential byte readout.
// ----------------------------------------------------------------------------
// One item is handled at a time, sequenced by a controller over a frame store
// with one write port and one registered read port. A draw reads and writes
// the upper page byte, and the lower one too when bits spill into the next
// page (the store is read and then written once per page). A read issues the
// memory read and then waits, if need be, for the output register to drain;
// the result sits in an output register so the next item is taken while it
// waits. A clear zeroes all SCREEN_COLUMNS*SCREEN_ROWS/8 bytes (504 at the
// defaults), one byte zeroed per cycle. After reset the same clearing sweep
// runs before the first item is accepted; configuration writes are taken at
// any time.
module page_framebuffer_column_blitter #(
  parameter int SCREEN_COLUMNS = 84,
  parameter int SCREEN_ROWS    = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd[1:0], x_pos[8:2], y_pos[14:9], column_bits[22:15]
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,  // last_byte
  // Blend mode register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // blend_mode
);
  import pfcb_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  // Sequencing.
  pfcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tdata[CMD_LSB +: 2]),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Store and arithmetic.
  pfcb_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_blend (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

[tb/sv/fb_readout_checker.sv]
// ----------------------------------------------------------------------------
// fb_readout_checker
// Watches the input, result and blend mode channels of the column blitter,
// keeps its own image of the frame store and checks every byte read out.
// ----------------------------------------------------------------------------
module fb_readout_checker #(
  parameter int SCREEN_COLUMNS = 84,
  parameter int SCREEN_ROWS    = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          reads_pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import pfcb_pkg::*;

  localparam int STORE_BYTES = SCREEN_COLUMNS * SCREEN_ROWS / 8;

  // One expected readout word.
  typedef struct packed {
    logic [7:0] pixels;
    logic       last;
  } readout_t;

  logic [7:0] fb_image [STORE_BYTES];
  int         read_ptr;
  logic       blend_or;
  readout_t   expected_reads [$];
  readout_t   oldest;

  // Count a failure and report only the first few of them.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Merge one byte into the image; indexes past the store are dropped.
  function automatic void merge_page_byte(input int idx, input logic [7:0] bits);
    if (idx < STORE_BYTES) begin
      fb_image[idx] = blend_or ? (fb_image[idx] | bits) : bits;
    end
  endfunction

  // Apply one accepted input word to the image and queue any readout.
  task automatic apply_word(input logic [23:0] word);
    logic [1:0]  cmd;
    logic [6:0]  x;
    logic [5:0]  y;
    logic [7:0]  bits;
    logic [15:0] shifted;
    int          idx;
    readout_t    rd;
    cmd  = word[1:0];
    x    = word[8:2];
    y    = word[14:9];
    bits = word[22:15];
    case (cmd)
      CMD_DRAW: begin
        shifted = {8'h00, bits} << y[2:0];
        idx     = int'(y[5:3]) * SCREEN_COLUMNS + int'(x);
        merge_page_byte(idx, shifted[7:0]);
        // Only bits pushed past the page touch the byte one page lower.
        if (y[2:0] != 3'd0 && shifted[15:8] != 8'h00) begin
          merge_page_byte(idx + SCREEN_COLUMNS, shifted[15:8]);
        end
      end
      CMD_CLEAR: begin
        foreach (fb_image[i]) fb_image[i] = 8'h00;
      end
      CMD_READ: begin
        if (read_ptr >= STORE_BYTES) read_ptr = 0;
        rd.pixels = fb_image[read_ptr];
        rd.last   = (read_ptr == STORE_BYTES - 1);
        expected_reads.push_back(rd);
        read_ptr = read_ptr + 1;
        if (read_ptr >= STORE_BYTES) read_ptr = 0;
      end
      default: ;
    endcase
  endtask

  // Track all three channels at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (fb_image[i]) fb_image[i] = 8'h00;
      read_ptr   = 0;
      blend_or   = 1'b1;
      fail_count = 0;
      expected_reads.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        blend_or = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (expected_reads.size() == 0) begin
          note_failure($sformatf("result word %02h with no read outstanding", out_tdata));
        end else begin
          oldest = expected_reads.pop_front();
          if (out_tdata !== oldest.pixels) begin
            note_failure($sformatf("out_byte mismatch, expected %02h, got %02h",
                                   oldest.pixels, out_tdata));
          end
          if (out_tlast !== oldest.last) begin
            note_failure($sformatf("last_byte mismatch, expected %0b, got %0b",
                                   oldest.last, out_tlast));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_word(in_tdata);
      end
    end
    reads_pending <= expected_reads.size();
  end

endmodule

[tb/sv/page_framebuffer_column_blitter_tb.sv]
// ----------------------------------------------------------------------------
// page_framebuffer_column_blitter_tb
// Drives draw, clear and read words into the column blitter in random bursts,
// stalls the result side on a changing pattern, switches the blend mode
// between phases and reports the verdict from the readout checker.
// ----------------------------------------------------------------------------
module page_framebuffer_column_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfcb_pkg::*;

  localparam int SCREEN_COLUMNS = 84;
  localparam int SCREEN_ROWS    = 48;
  localparam int STORE_BYTES    = SCREEN_COLUMNS * SCREEN_ROWS / 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES   = 12;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 225;
  // A clear can still be sweeping the store after the last result arrived.
  localparam int SETTLE_CYCLES  = STORE_BYTES + 16;
  localparam int CYCLE_LIMIT    = 600000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // cmd[1:0], x_pos[8:2], y_pos[14:9], column_bits[22:15]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // out_byte[7:0]
  logic        out_tlast;         // last_byte
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_data   = 1'b0; // blend_mode

  int       reads_pending;
  int       fail_count;
  int       burst_left  = 0;
  int       rx_count    = 0;
  int       cycle_count = 0;
  rx_mode_t rx_mode     = RX_OPEN;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  page_framebuffer_column_blitter #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fb_readout_checker #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) readout_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .reads_pending(reads_pending),
    .fail_count   (fail_count)
  );

  // Result side stall pattern, with the mode picked anew at random as rx_count runs.
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count % 300 == 299) begin
      rx_mode <= rx_mode_t'($urandom_range(3));
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(1));
      RX_SPARSE: out_tready <= (rx_count[2:0] == 3'd0);
      default:   out_tready <= (rx_count[4:3] != 2'd0);
    endcase
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Send one word, opening a new burst after a short gap when one runs out.
  task automatic send_word(input logic [1:0] cmd, input logic [6:0] x,
                           input logic [5:0] y, input logic [7:0] bits);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, bits, y, x, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Change the blend mode once the block has gone quiet.
  task automatic set_blend(input logic mode);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    burst_left = 0;
  endtask

  // One random word; mostly draws and reads over the visible screen.
  task automatic send_random_word(output bit counted);
    int         pick;
    logic [1:0] cmd;
    logic [6:0] x;
    logic [5:0] y;
    logic [7:0] bits;
    pick = $urandom_range(99);
    x = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                 : 7'($urandom_range(SCREEN_COLUMNS - 1));
    y = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                 : 6'($urandom_range(SCREEN_ROWS - 1));
    case ($urandom_range(7))
      0:       bits = 8'h00;
      1:       bits = 8'hFF;
      default: bits = 8'($urandom_range(255));
    endcase
    if (pick < 2) begin
      cmd = CMD_UNUSED;
    end else if (pick < 5) begin
      cmd = CMD_CLEAR;
    end else if (pick < 45) begin
      cmd = CMD_READ;
    end else begin
      cmd = CMD_DRAW;
    end
    send_word(cmd, x, y, bits);
    counted = (cmd != CMD_UNUSED);
  endtask

  initial begin
    int   sent;
    bit   counted;
    logic mode;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words in blend mode, the reset setting.
    send_word(CMD_READ,  7'd0,   6'd0,  8'h00);  // empty store, first byte
    send_word(CMD_DRAW,  7'd1,   6'd0,  8'hFF);
    send_word(CMD_READ,  7'd0,   6'd0,  8'h00);  // reads back the full column
    send_word(CMD_DRAW,  7'd2,   6'd3,  8'hF8);  // spills into the next page
    send_word(CMD_DRAW,  7'd2,   6'd0,  8'h01);  // merged by OR
    send_word(CMD_READ,  7'd0,   6'd0,  8'h00);
    send_word(CMD_DRAW,  7'd83,  6'd47, 8'h81);  // last byte, spill falls off the store
    send_word(CMD_DRAW,  7'd127, 6'd63, 8'hFF);  // wholly outside the store
    send_word(CMD_DRAW,  7'd100, 6'd0,  8'h5A);  // past the screen, lands on the next page
    send_word(CMD_DRAW,  7'd5,   6'd5,  8'h07);  // shifted but no spill
    send_word(CMD_DRAW,  7'd6,   6'd9,  8'h00);  // empty bitmap with a shift
    send_word(CMD_UNUSED, 7'($urandom_range(127)), 6'($urandom_range(63)),
              8'($urandom_range(255)));

    // Directed words in overwrite mode.
    set_blend(1'b0);
    send_word(CMD_DRAW,  7'd2,   6'd1,  8'h01);  // upper byte replaced, spill byte kept
    send_word(CMD_DRAW,  7'd3,   6'd7,  8'hFF);  // both pages replaced
    send_word(CMD_READ,  7'd0,   6'd0,  8'h00);
    send_word(CMD_DRAW,  7'd3,   6'd0,  8'h00);
    send_word(CMD_READ,  7'd0,   6'd0,  8'h00);
    send_word(CMD_CLEAR, 7'd0,   6'd0,  8'h00);
    send_word(CMD_READ,  7'd0,   6'd0,  8'h00);  // read position survives the clear
    send_word(CMD_DRAW,  7'd0,   6'd63, 8'hFF);  // bottom row, outside the store
    send_word(CMD_DRAW,  7'd83,  6'd40, 8'hAA);

    // Random phases, each with its own blend setting.
    for (int p = 0; p < PHASES; p++) begin
      mode = (p < 4) ? ~p[0] : 1'($urandom_range(1));
      set_blend(mode);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_word(counted);
        if (counted) sent++;
      end
    end

    // Drain and report.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && reads_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[page_framebuffer_column_blitter.f]
rtl/core/pfcb_pkg.sv
rtl/core/pfcb_ctrl.sv
rtl/core/pfcb_datapath.sv
rtl/core/page_framebuffer_column_blitter.sv
tb/sv/fb_readout_checker.sv
tb/sv/page_framebuffer_column_blitter_tb.sv
